>>> design/gius_pkg.sv
// types and constants shared by the box suppression block
// no dependencies; compile first
package gius_pkg;

   localparam int COORD_W = 16;
   localparam int AREA_W  = 32;
   localparam int EDGE_W  = 18;
   localparam int UNI_W   = 33;
   localparam int PROD_W  = 49;
   localparam int THR_W   = 16;
   localparam int SLOT_W  = 7;

   localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

   // one stored kept box
   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic [COORD_W-1:0]        width;
      logic [COORD_W-1:0]        height;
      logic [AREA_W-1:0]         area;
   } box_entry_type;

   // status from the compare pipeline to the sequencer
   typedef struct packed {
      logic busy;
      logic hit;
   } iou_stat_type;

endpackage

>>> design/gius_channels.sv
// valid/ready channel interfaces for box words and result words
// depends on gius_pkg
interface gius_req_if import gius_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] box_left;
   logic signed [COORD_W-1:0] box_top;
   logic [COORD_W-1:0]        box_width;
   logic [COORD_W-1:0]        box_height;
   logic                      first_of_frame;

   modport source (output valid, box_left, box_top, box_width, box_height,
                   first_of_frame, input ready);
   modport sink (input valid, box_left, box_top, box_width, box_height,
                 first_of_frame, output ready);
endinterface

interface gius_rsp_if import gius_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              keep;
   logic [SLOT_W-1:0] kept_slot;
   logic              store_overflow;

   modport source (output valid, keep, kept_slot, store_overflow, input ready);
   modport sink (input valid, keep, kept_slot, store_overflow, output ready);
endinterface

>>> design/gius_store.sv
// kept box memory: one write port, one read port with registered data
// depends on gius_pkg
module gius_store import gius_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  box_entry_type    wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output box_entry_type    rd_data
);

   box_entry_type mem [DEPTH];
   box_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/gius_iou.sv
// pipelined overlap test of the current box against one stored box per cycle
// depends on gius_pkg; fed by gius_store read data
module gius_iou import gius_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [THR_W-1:0]          thr,
   input  logic signed [COORD_W-1:0] item_left,
   input  logic signed [COORD_W-1:0] item_top,
   input  logic [COORD_W-1:0]        item_width,
   input  logic [COORD_W-1:0]        item_height,
   input  logic [AREA_W-1:0]         item_area,
   input  logic                      issue,
   input  box_entry_type             rd_data,
   output iou_stat_type              stat
);

   logic [5:0] v_ff;
   logic [5:0] v_in;

   logic signed [EDGE_W-1:0] al_ff, at_ff, ar_ff, ab_ff;
   logic signed [EDGE_W-1:0] al_in, at_in, ar_in, ab_in;

   logic signed [EDGE_W-1:0] kl, kt, kr, kb;
   logic signed [EDGE_W-1:0] lox_in, hix_in, loy_in, hiy_in;
   logic signed [EDGE_W-1:0] lox_ff, hix_ff, loy_ff, hiy_ff;
   logic [AREA_W-1:0]        ka1_ff, ka2_ff, ka3_ff;

   logic signed [EDGE_W-1:0] dx, dy;
   logic [COORD_W-1:0]       iw_in, ih_in, iw_ff, ih_ff;

   logic [AREA_W-1:0] inter3_in, inter3_ff, inter4_ff, inter5_ff;
   logic [UNI_W-1:0]  uni_in, uni_ff;
   logic [PROD_W-1:0] prod_in, prod_ff;

   // edges of the current box, held steady for a whole scan
   assign al_in = EDGE_W'(item_left);
   assign at_in = EDGE_W'(item_top);
   assign ar_in = al_in + $signed({2'b00, item_width});
   assign ab_in = at_in + $signed({2'b00, item_height});

   always_ff @(posedge clock) begin
      al_ff <= al_in;
      at_ff <= at_in;
      ar_ff <= ar_in;
      ab_ff <= ab_in;
   end

   // stage 1: intersection bounds
   assign kl = EDGE_W'(rd_data.left);
   assign kt = EDGE_W'(rd_data.top);
   assign kr = kl + $signed({2'b00, rd_data.width});
   assign kb = kt + $signed({2'b00, rd_data.height});

   assign lox_in = (al_ff > kl) ? al_ff : kl;
   assign loy_in = (at_ff > kt) ? at_ff : kt;
   assign hix_in = (ar_ff < kr) ? ar_ff : kr;
   assign hiy_in = (ab_ff < kb) ? ab_ff : kb;

   // stage 2: clamped extents, never wider than the narrower box
   assign dx    = hix_ff - lox_ff;
   assign dy    = hiy_ff - loy_ff;
   assign iw_in = (hix_ff > lox_ff) ? dx[COORD_W-1:0] : '0;
   assign ih_in = (hiy_ff > loy_ff) ? dy[COORD_W-1:0] : '0;

   // stage 3: intersection area
   assign inter3_in = AREA_W'(iw_ff) * AREA_W'(ih_ff);

   // stage 4: union, exact in 33 bits
   assign uni_in = UNI_W'(item_area) + UNI_W'(ka3_ff) - UNI_W'(inter3_ff);

   // stage 5: threshold times union
   assign prod_in = PROD_W'(thr) * PROD_W'(uni_ff);

   always_ff @(posedge clock) begin
      lox_ff    <= lox_in;
      hix_ff    <= hix_in;
      loy_ff    <= loy_in;
      hiy_ff    <= hiy_in;
      ka1_ff    <= rd_data.area;
      iw_ff     <= iw_in;
      ih_ff     <= ih_in;
      ka2_ff    <= ka1_ff;
      inter3_ff <= inter3_in;
      ka3_ff    <= ka2_ff;
      uni_ff    <= uni_in;
      inter4_ff <= inter3_ff;
      prod_ff   <= prod_in;
      inter5_ff <= inter4_ff;
   end

   // v_ff[0] tags the read data of the store, in the cycle after issue
   assign v_in = {v_ff[4:0], issue};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign stat.busy = |v_ff;
   assign stat.hit  = v_ff[5] && ({1'b0, inter5_ff, 16'h0000} > prod_ff);

endmodule

>>> design/greedy_iou_box_suppression.sv
// greedy non-maximum suppression by IoU over a memory of kept boxes
// depends on gius_pkg, gius_channels, gius_store, gius_iou
//
//  channel   dir  handshake          word
//  req_ch    in   valid/ready        box_left, box_top, box_width, box_height,
//                                    first_of_frame
//  rsp_ch    out  valid/ready        keep, kept_slot, store_overflow
//  csr       in   write enable only  iou_threshold
//
// a box's time from accept to result grows with kept_count: one store read per
//   kept box, then the compare pipeline behind the store's read port; an empty
//   list or a frame start skips the store reads
// one box at a time; a new box is taken while a result waits on rsp_ch
// reset clears the kept count and loads the threshold; the store is not cleared
// a stalled result holds the block in its last step until rsp_ch takes it
module greedy_iou_box_suppression import gius_pkg::*; #(
   parameter int MAX_KEPT = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [THR_W-1:0] csr_write_data,
   gius_req_if.sink         req_ch,
   gius_rsp_if.source       rsp_ch
);

   localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W = $clog2(MAX_KEPT + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEPT);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [THR_W-1:0] thr_ff, thr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             suppress_ff, suppress_in;

   logic signed [COORD_W-1:0] left_ff, top_ff;
   logic [COORD_W-1:0]        width_ff, height_ff;
   logic [AREA_W-1:0]         area_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_keep_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_ovf_ff;

   logic          req_fire;
   logic          done_fire;
   logic          issue;
   logic          keep;
   logic          wr_en;
   box_entry_type wr_data;
   box_entry_type rd_data;
   iou_stat_type  stat;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign issue        = (state_ff == ST_SCAN);
   assign done_fire    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   assign keep         = !suppress_ff;
   assign wr_en        = done_fire && keep && (count_ff < CNT_MAX);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      suppress_in = suppress_ff || stat.hit;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               suppress_in = 1'b0;
               rd_idx_in   = '0;
               // first box of a frame empties the list before its test
               if (req_ch.first_of_frame) begin
                  count_in = '0;
               end
               if (req_ch.first_of_frame || count_ff == '0) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_idx_in = rd_idx_ff + 1'b1;
            if (rd_idx_ff == count_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_fire) begin
               state_in = ST_IDLE;
               if (wr_en) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign thr_in = csr_write_enable ? csr_write_data : thr_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THR_RESET;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         suppress_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         suppress_ff  <= suppress_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         left_ff   <= req_ch.box_left;
         top_ff    <= req_ch.box_top;
         width_ff  <= req_ch.box_width;
         height_ff <= req_ch.box_height;
      end
      area_ff <= AREA_W'(width_ff) * AREA_W'(height_ff);
      if (done_fire) begin
         rsp_keep_ff <= keep;
         rsp_slot_ff <= SLOT_W'(count_ff);
         rsp_ovf_ff  <= keep && (count_ff == CNT_MAX);
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.keep           = rsp_keep_ff;
   assign rsp_ch.kept_slot      = rsp_slot_ff;
   assign rsp_ch.store_overflow = rsp_ovf_ff;

   assign wr_data.left   = left_ff;
   assign wr_data.top    = top_ff;
   assign wr_data.width  = width_ff;
   assign wr_data.height = height_ff;
   assign wr_data.area   = area_ff;

   gius_store #(
      .DEPTH (MAX_KEPT),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   gius_iou u_iou (
      .clock       (clock),
      .reset       (reset),
      .thr         (thr_ff),
      .item_left   (left_ff),
      .item_top    (top_ff),
      .item_width  (width_ff),
      .item_height (height_ff),
      .item_area   (area_ff),
      .issue       (issue),
      .rd_data     (rd_data),
      .stat        (stat)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("kept count above store depth");

   a_pipe_empty_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !stat.busy)
      else $error("new box accepted with compares still in flight");

   a_store_grows: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("store write without count step");

   a_result_after_done: assert property (@(posedge clock) disable iff (reset)
      done_fire |=> rsp_valid_ff)
      else $error("finished box gave no result word");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      issue |-> rd_idx_ff < count_ff)
      else $error("store read beyond kept count");

endmodule
